// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PSS_ASSERT_IMPLY(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pss check failed: same-cycle implication");

// next-cycle implication
`define PSS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pss check failed: next-cycle implication");

`endif

// ----- rtl/pss_pkg.sv -----
// ----------------------------------------------------------------------------
// pss_pkg
// Types and constants shared by the pitch sweep sound sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package pss_pkg;

    localparam int FREQ_W = 16;
    localparam int BYTE_W = 8;
    localparam int OP_W   = 2;
    localparam int IDX_W  = 3;

    localparam logic [OP_W-1:0] OP_INIT    = 2'd0;
    localparam logic [OP_W-1:0] OP_TRIGGER = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK    = 2'd2;

    localparam logic [IDX_W-1:0] REG_START_FREQ   = 3'd0;
    localparam logic [IDX_W-1:0] REG_END_FREQ     = 3'd1;
    localparam logic [IDX_W-1:0] REG_STEP_SIZE    = 3'd2;
    localparam logic [IDX_W-1:0] REG_SWEEP_LEN    = 3'd3;
    localparam logic [IDX_W-1:0] REG_RELEASE_LEN  = 3'd4;
    localparam logic [IDX_W-1:0] REG_ATTACK_DECAY = 3'd5;
    localparam logic [IDX_W-1:0] REG_SUSTAIN_REL  = 3'd6;

    localparam logic [BYTE_W-1:0] CTL_SILENT   = 8'h00;
    localparam logic [BYTE_W-1:0] CTL_GATE_OFF = 8'h10;
    localparam logic [BYTE_W-1:0] CTL_GATE_ON  = 8'h11;

    localparam logic [FREQ_W-1:0] RST_START_FREQ   = 16'h1800;
    localparam logic [FREQ_W-1:0] RST_END_FREQ     = 16'h0300;
    localparam logic [FREQ_W-1:0] RST_STEP_SIZE    = 16'd448;
    localparam logic [BYTE_W-1:0] RST_SWEEP_LEN    = 8'd12;
    localparam logic [BYTE_W-1:0] RST_RELEASE_LEN  = 8'd5;
    localparam logic [BYTE_W-1:0] RST_ATTACK_DECAY = 8'h03;
    localparam logic [BYTE_W-1:0] RST_SUSTAIN_REL  = 8'h04;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_SWEEP   = 2'd1,
        PH_RELEASE = 2'd2
    } phase_t;

    typedef struct packed {
        logic [FREQ_W-1:0] start_freq;
        logic [FREQ_W-1:0] end_freq;
        logic [FREQ_W-1:0] step_size;
        logic [BYTE_W-1:0] sweep_len;
        logic [BYTE_W-1:0] release_len;
        logic [BYTE_W-1:0] attack_decay;
        logic [BYTE_W-1:0] sustain_rel;
    } cfg_t;

    typedef struct packed {
        logic [FREQ_W-1:0] voice_frequency;
        logic [BYTE_W-1:0] voice_control;
        logic              gate_restarted;
        logic [BYTE_W-1:0] envelope_ad;
        logic [BYTE_W-1:0] envelope_sr;
        phase_t            phase;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/pss_cfg.sv -----
// ----------------------------------------------------------------------------
// pss_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module pss_cfg (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [pss_pkg::IDX_W-1:0]    cfg_index,
    input  wire logic [pss_pkg::FREQ_W-1:0]   cfg_data,
    output pss_pkg::cfg_t                     cfg
);

    pss_pkg::cfg_t cfg_reg;
    pss_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                pss_pkg::REG_START_FREQ:   cfg_next.start_freq   = cfg_data;
                pss_pkg::REG_END_FREQ:     cfg_next.end_freq     = cfg_data;
                pss_pkg::REG_STEP_SIZE:    cfg_next.step_size    = cfg_data;
                pss_pkg::REG_SWEEP_LEN:    cfg_next.sweep_len    = cfg_data[pss_pkg::BYTE_W-1:0];
                pss_pkg::REG_RELEASE_LEN:  cfg_next.release_len  = cfg_data[pss_pkg::BYTE_W-1:0];
                pss_pkg::REG_ATTACK_DECAY: cfg_next.attack_decay = cfg_data[pss_pkg::BYTE_W-1:0];
                pss_pkg::REG_SUSTAIN_REL:  cfg_next.sustain_rel  = cfg_data[pss_pkg::BYTE_W-1:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_freq   <= pss_pkg::RST_START_FREQ;
            cfg_reg.end_freq     <= pss_pkg::RST_END_FREQ;
            cfg_reg.step_size    <= pss_pkg::RST_STEP_SIZE;
            cfg_reg.sweep_len    <= pss_pkg::RST_SWEEP_LEN;
            cfg_reg.release_len  <= pss_pkg::RST_RELEASE_LEN;
            cfg_reg.attack_decay <= pss_pkg::RST_ATTACK_DECAY;
            cfg_reg.sustain_rel  <= pss_pkg::RST_SUSTAIN_REL;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- rtl/pss_engine.sv -----
// ----------------------------------------------------------------------------
// pss_engine
// Voice state and the per-word update for init, trigger and tick.
// ----------------------------------------------------------------------------
`default_nettype none

module pss_engine (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        fire,
    input  wire logic [pss_pkg::OP_W-1:0]    operation,
    input  wire logic [pss_pkg::BYTE_W-1:0]  frame_count,
    input  pss_pkg::cfg_t                    cfg,
    output pss_pkg::result_t                 result
);

    pss_pkg::phase_t             phase_reg, phase_next;
    logic [pss_pkg::BYTE_W-1:0]  frames_reg, frames_next;
    logic [pss_pkg::FREQ_W-1:0]  freq_reg, freq_next;
    logic [pss_pkg::BYTE_W-1:0]  last_frame_reg, last_frame_next;
    logic [pss_pkg::BYTE_W-1:0]  ctl_reg, ctl_next;
    logic [pss_pkg::BYTE_W-1:0]  ad_reg, ad_next;
    logic [pss_pkg::BYTE_W-1:0]  sr_reg, sr_next;
    logic                        restarted;
    logic [pss_pkg::FREQ_W:0]    floor_sum;
    logic [pss_pkg::BYTE_W-1:0]  frames_dec;
    logic                        advance;

    assign floor_sum  = {1'b0, cfg.end_freq} + {1'b0, cfg.step_size};
    assign frames_dec = frames_reg - 8'd1;
    assign advance    = (phase_reg != pss_pkg::PH_IDLE) && (frame_count != last_frame_reg);

    always_comb
    begin
        phase_next      = phase_reg;
        frames_next     = frames_reg;
        freq_next       = freq_reg;
        last_frame_next = last_frame_reg;
        ctl_next        = ctl_reg;
        ad_next         = ad_reg;
        sr_next         = sr_reg;
        restarted       = 1'b0;
        unique case (operation)
            pss_pkg::OP_INIT:
            begin
                ctl_next        = pss_pkg::CTL_SILENT;
                phase_next      = pss_pkg::PH_IDLE;
                last_frame_next = frame_count;
            end
            pss_pkg::OP_TRIGGER:
            begin
                ad_next     = cfg.attack_decay;
                sr_next     = cfg.sustain_rel;
                freq_next   = cfg.start_freq;
                ctl_next    = pss_pkg::CTL_GATE_ON;
                restarted   = 1'b1;
                frames_next = cfg.sweep_len;
                phase_next  = pss_pkg::PH_SWEEP;
            end
            pss_pkg::OP_TICK:
            begin
                if (advance)
                begin
                    last_frame_next = frame_count;
                    frames_next     = frames_dec;
                    unique case (phase_reg)
                        pss_pkg::PH_SWEEP:
                        begin
                            if ({1'b0, freq_reg} > floor_sum)
                                freq_next = freq_reg - cfg.step_size;
                            else
                                freq_next = cfg.end_freq;
                            if (frames_dec == '0)
                            begin
                                ctl_next    = pss_pkg::CTL_GATE_OFF;
                                frames_next = cfg.release_len;
                                phase_next  = pss_pkg::PH_RELEASE;
                            end
                        end
                        pss_pkg::PH_RELEASE:
                        begin
                            if (frames_dec == '0)
                            begin
                                ctl_next   = pss_pkg::CTL_SILENT;
                                freq_next  = '0;
                                phase_next = pss_pkg::PH_IDLE;
                            end
                        end
                        default:
                        begin
                            frames_next = frames_reg;
                        end
                    endcase
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= pss_pkg::PH_IDLE;
            frames_reg     <= '0;
            freq_reg       <= '0;
            last_frame_reg <= '0;
            ctl_reg        <= pss_pkg::CTL_SILENT;
            ad_reg         <= '0;
            sr_reg         <= '0;
        end
        else if (fire)
        begin
            phase_reg      <= phase_next;
            frames_reg     <= frames_next;
            freq_reg       <= freq_next;
            last_frame_reg <= last_frame_next;
            ctl_reg        <= ctl_next;
            ad_reg         <= ad_next;
            sr_reg         <= sr_next;
        end
    end

    always_comb
    begin
        result.voice_frequency = freq_next;
        result.voice_control   = ctl_next;
        result.gate_restarted  = restarted;
        result.envelope_ad     = ad_next;
        result.envelope_sr     = sr_next;
        result.phase           = phase_next;
    end

endmodule

`default_nettype wire

// ----- rtl/pitch_sweep_sound_sequencer.sv -----
// ----------------------------------------------------------------------------
// pitch_sweep_sound_sequencer
// Falling-pitch effect sequencer for one tone voice: one result word for
// every command word, with input and output registers around the update.
// ----------------------------------------------------------------------------
//   channel   dir  handshake         payload
//   s_axis    in   tvalid / tready   tdata[15:0]: operation, frame_count
//   m_axis    out  tvalid / tready   tdata[47:0]: voice state after the word
//   cfg       in   cfg_we            cfg_index, cfg_data, no wait, no read-back
//
// One word per cycle sustained while m_axis is ready; each word passes the input
// register and then the result register around the state update.
// Reset clears the voice state and loads the register defaults; no sweep.
// A stalled m_axis holds its word while one more word waits in the input
// register; s_tready drops only when both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module pitch_sweep_sound_sequencer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [1:0] operation, [9:2] frame_count, [15:10] zero
    input  wire logic [15:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [15:0] voice_frequency, [23:16] voice_control, [24] gate_restarted,
    // [32:25] envelope_ad, [40:33] envelope_sr, [42:41] phase, [47:43] zero
    output logic [47:0]      m_axis_tdata,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    `include "assert_macros.svh"

    pss_pkg::cfg_t                 cfg;
    pss_pkg::result_t              result;
    pss_pkg::result_t              out_reg;
    logic                          in_valid_reg;
    logic [pss_pkg::OP_W-1:0]      op_reg;
    logic [pss_pkg::BYTE_W-1:0]    frame_reg;
    logic                          out_valid_reg;
    logic                          fire;

    assign fire          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || fire;

    pss_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pss_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .operation   (op_reg),
        .frame_count (frame_reg),
        .cfg         (cfg),
        .result      (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (fire)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            op_reg    <= s_axis_tdata[1:0];
            frame_reg <= s_axis_tdata[9:2];
        end
        if (fire)
            out_reg <= result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0,
                            out_reg.phase,
                            out_reg.envelope_sr,
                            out_reg.envelope_ad,
                            out_reg.gate_restarted,
                            out_reg.voice_control,
                            out_reg.voice_frequency};

    `PSS_ASSERT_IMPLY(a_idle_silent,
        out_valid_reg && (out_reg.phase == pss_pkg::PH_IDLE),
        out_reg.voice_control == pss_pkg::CTL_SILENT)
    `PSS_ASSERT_IMPLY(a_restart_gate_on,
        out_valid_reg && out_reg.gate_restarted,
        (out_reg.phase == pss_pkg::PH_SWEEP) && (out_reg.voice_control == pss_pkg::CTL_GATE_ON))
    `PSS_ASSERT_NEXT(a_fill_output,
        in_valid_reg && !out_valid_reg,
        out_valid_reg)

endmodule

`default_nettype wire
